// ----- hw/rtl/memt_pkg.sv -----
// Shared types and constants for the twister generator.
package memt_pkg;

  localparam int unsigned NWORDS = 19;
  localparam int unsigned NJBITS = 1280;

  localparam logic [63:0] TWIST_MAT   = 64'h1afefd1526d3952b;
  localparam logic [63:0] TEMPER_MASK = 64'h3a23d78e8fb5e349;
  localparam logic [63:0] SEED_MULT   = 64'd6364136223846793005;

  localparam logic [1:0] REQ_NEXT = 2'd0;
  localparam logic [1:0] REQ_SEED = 2'd1;
  localparam logic [1:0] REQ_JUMP = 2'd2;

  // bit k of the jump polynomial sits at index NJBITS-1-k
  localparam logic [NJBITS-1:0] JUMP_POLY = {
    200'ha4704d47efb161016e3736c80e933688017732e3ffc4115893,
    200'h8838ba22bb5cddf444d6f3fb8f3431c350ef813cceb90a9587,
    200'hb8e1626e74dc53831fba639564f313238548597b13bc13679e,
    200'h172cf95e9fabac836d6888253c34e4ac182c6779be5414e2cb,
    200'h1933412fcbdc47a055d72c339f5033276d8cc5b491ec343bbe,
    200'h7f5467cd6ed8e33b8f1305b10e3b134e67c62358665d196e5c,
    80'h2030a9e45ae42eab5e0c};

  typedef struct packed {
    logic       step;      // one recurrence step, state rotates by one
    logic       out_load;  // capture tempered word
    logic       acc_clr;
    logic       acc_xor;
    logic       acc_load;  // accumulator replaces state
    logic       seed_load; // shift seed word in
    logic       mul_en;
    logic [1:0] mul_ph;
    logic       seed_wr;   // shift product + index in
    logic       fb_wr;     // product + index to feedback word
    logic [4:0] idx;
  } memt_cmd_t;

endpackage

// ----- hw/rtl/memt_ctrl.sv -----
// Sequencer for next, seed and jump requests.
module memt_ctrl import memt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  output logic        out_valid,
  input  logic        out_ready,
  output memt_cmd_t   cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SEED, S_JUMP, S_LOAD} state_t;

  localparam logic [4:0]  LAST_IDX = 5'(NWORDS);
  localparam logic [10:0] LAST_BIT = 11'(NJBITS - 1);

  state_t      st_r, st_nxt;
  logic        ov_r, ov_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [10:0] k_r, k_nxt;
  logic        acc;

  assign in_ready  = (st_r == S_IDLE) && (!ov_r || out_ready);
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    st_nxt  = st_r;
    ov_nxt  = ov_r && !out_ready;
    idx_nxt = idx_r;
    ph_nxt  = ph_r;
    k_nxt   = k_r;
    cmd     = '0;
    cmd.idx = idx_r;
    cmd.mul_ph = ph_r;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          case (in_req_type)
            REQ_NEXT: begin
              cmd.step = 1'b1;
              cmd.out_load = 1'b1;
              ov_nxt = 1'b1;
            end
            REQ_SEED: begin
              cmd.seed_load = 1'b1;
              idx_nxt = 5'd1;
              ph_nxt = 2'd0;
              st_nxt = S_SEED;
            end
            REQ_JUMP: begin
              cmd.acc_clr = 1'b1;
              k_nxt = '0;
              st_nxt = S_JUMP;
            end
            default: ;
          endcase
        end
      end
      S_SEED: begin
        if (ph_r != 2'd3) begin
          cmd.mul_en = 1'b1;
          ph_nxt = ph_r + 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (idx_r == LAST_IDX) begin
            cmd.fb_wr = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            cmd.seed_wr = 1'b1;
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      S_JUMP: begin
        cmd.step = 1'b1;
        cmd.acc_xor = JUMP_POLY[LAST_BIT - k_r];
        if (k_r == LAST_BIT) st_nxt = S_LOAD;
        else k_nxt = k_r + 11'd1;
      end
      S_LOAD: begin
        cmd.acc_load = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ov_r  <= 1'b0;
      idx_r <= '0;
      ph_r  <= '0;
      k_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
      ph_r  <= ph_nxt;
      k_r   <= k_nxt;
    end
  end

endmodule

// ----- hw/rtl/memt_dpath.sv -----
// State words, recurrence step, seed multiplier and jump accumulator.
module memt_dpath import memt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  memt_cmd_t   cmd,
  input  logic [63:0] in_seed_value,
  output logic [63:0] out_random_word
);

  // words are kept rotated: w_r[0] is always the current position
  logic [63:0] w_r [NWORDS];
  logic [63:0] w_nxt [NWORDS];
  logic [63:0] a_r [NWORDS];
  logic [63:0] fb_r, fb_nxt, afb_r;
  logic [63:0] y_r, prod_r;
  logic [63:0] v, fbs, nw, y, q, mres, mword;
  logic [31:0] op_a, op_b;

  always_comb begin
    v   = {w_r[0][63:1], w_r[1][0]};
    fbs = (v >> 1) ^ (v[0] ? TWIST_MAT : 64'd0) ^ w_r[7] ^ fb_r ^ (fb_r << 22);
    nw  = v ^ fbs ^ (fbs >> 37);
    y   = nw ^ (nw << 6) ^ (w_r[5] & TEMPER_MASK);
  end

  // low 64 bits of q*SEED_MULT from three 32x32 partial products
  always_comb begin
    q = w_r[NWORDS-1] ^ (w_r[NWORDS-1] >> 62);
    case (cmd.mul_ph)
      2'd0: begin op_a = q[31:0];  op_b = SEED_MULT[31:0];  end
      2'd1: begin op_a = q[31:0];  op_b = SEED_MULT[63:32]; end
      default: begin op_a = q[63:32]; op_b = SEED_MULT[31:0]; end
    endcase
    mres  = {32'd0, op_a} * {32'd0, op_b};
    mword = prod_r + 64'(cmd.idx);
  end

  always_comb begin
    for (int i = 0; i < NWORDS; i++) w_nxt[i] = w_r[i];
    fb_nxt = fb_r;
    if (cmd.step) begin
      for (int i = 0; i < NWORDS - 1; i++) w_nxt[i] = w_r[i+1];
      w_nxt[NWORDS-1] = nw;
      fb_nxt = fbs;
    end else if (cmd.seed_load || cmd.seed_wr) begin
      for (int i = 0; i < NWORDS - 1; i++) w_nxt[i] = w_r[i+1];
      w_nxt[NWORDS-1] = cmd.seed_load ? in_seed_value : mword;
    end else if (cmd.fb_wr) begin
      fb_nxt = mword;
    end else if (cmd.acc_load) begin
      for (int i = 0; i < NWORDS; i++) w_nxt[i] = a_r[i];
      fb_nxt = afb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NWORDS; i++) w_r[i] <= '0;
      fb_r <= '0;
    end else begin
      for (int i = 0; i < NWORDS; i++) w_r[i] <= w_nxt[i];
      fb_r <= fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) y_r <= y;
    if (cmd.mul_en) begin
      if (cmd.mul_ph == 2'd0) prod_r <= mres;
      else prod_r <= prod_r + {mres[31:0], 32'd0};
    end
    if (cmd.acc_clr) begin
      for (int i = 0; i < NWORDS; i++) a_r[i] <= '0;
      afb_r <= '0;
    end else if (cmd.acc_xor) begin
      for (int i = 0; i < NWORDS; i++) a_r[i] <= a_r[i] ^ w_r[i];
      afb_r <= afb_r ^ fb_r;
    end
  end

  assign out_random_word = y_r;

endmodule

// ----- hw/rtl/memt_prng_with_jump.sv -----
// Top level of the 64-bit twister generator with jump-ahead.
//   channel  direction  fields
//   in_      input      in_req_type[1:0], in_seed_value[63:0]
//   out_     output     out_random_word[63:0]  (next requests only)
// Next: back to back unless the output stalls; the word waits in an output register.
// Seed: seed word load, then one shared 32x32 multiplier used three times per word.
// Jump: clear, then one recurrence step per cycle for each jump bit, final copy.
// Reset clears all state words; a stalled output blocks new requests only
// once the output register is full and not being taken.
module memt_prng_with_jump import memt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_random_word
);

  memt_cmd_t cmd;

  memt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  memt_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_seed_value  (in_seed_value),
    .out_random_word(out_random_word)
  );

endmodule

// ----- hw/rtl/memt_checker.sv -----
// Port-level checks for the twister generator.
module memt_checker import memt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_random_word
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_word))
    else $error("stalled output changed");

  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_SEED |=> !in_ready)
    else $error("ready during seed");

  a_jump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_JUMP |=> !in_ready)
    else $error("ready during jump");

  a_next_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_NEXT |=> out_valid)
    else $error("next transfer gave no result");

endmodule

bind memt_prng_with_jump memt_checker u_memt_checker (.*);
